FILE: rtl/core/cme_pkg.sv
// ----------------------------------------------------------------------------
// cme_pkg
// Shared types and constants for the CIGAR/MD alignment expander.
// ----------------------------------------------------------------------------
`default_nettype none

package cme_pkg;

  // Request codes
  localparam logic [2:0] REQ_QUERY = 3'd0;
  localparam logic [2:0] REQ_CIGAR = 3'd1;
  localparam logic [2:0] REQ_MD    = 3'd2;
  localparam logic [2:0] REQ_FETCH = 3'd3;
  localparam logic [2:0] REQ_START = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_OP    = 3'd1;
  localparam logic [2:0] ERR_Q_OVERRUN = 3'd2;
  localparam logic [2:0] ERR_MALFORMED = 3'd3;
  localparam logic [2:0] ERR_FULL      = 3'd4;
  localparam logic [2:0] ERR_MD_OVER   = 3'd5;

  // Characters
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_GAP   = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic RES_SUMMARY = 1'b0;
  localparam logic RES_COLUMN  = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_value;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  query_col;
    logic [7:0]  subject_col;
    logic        col_last;
    logic [12:0] q_begin;
    logic [12:0] q_end;
    logic        s_begin;
    logic [13:0] s_end;
    logic [2:0]  error_code;
  } result_t;

  // Classified command handed from front to back
  typedef struct packed {
    item_t      item;
    logic       is_digit;
    logic [3:0] digit;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/cme_front.sv
// ----------------------------------------------------------------------------
// cme_front
// Accepts items, classifies digits and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cme_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire cme_pkg::item_t item,
  output logic                busy,
  output logic                cmd_valid,
  output cme_pkg::cmd_t       cmd,
  input  wire logic           cmd_take
);

  cme_pkg::cmd_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;
  cme_pkg::cmd_t incoming;

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = entry[rd_ptr];

  always_comb begin
    incoming.item     = item;
    incoming.is_digit = (item.char_value >= cme_pkg::CH_ZERO) &&
                        (item.char_value <= cme_pkg::CH_NINE);
    incoming.digit    = 4'(item.char_value - cme_pkg::CH_ZERO);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cme_back.sv
// ----------------------------------------------------------------------------
// cme_back
// Executes queued commands: stores bases, expands CIGAR runs, applies MD
// and reads columns out.
// ----------------------------------------------------------------------------
`default_nettype none

module cme_back #(
  parameter int MAX_QUERY   = 4096,
  parameter int MAX_COLUMNS = 8192
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire cme_pkg::cmd_t cmd,
  output logic               cmd_take,
  output logic               result_valid,
  output cme_pkg::result_t   result
);

  localparam int QA  = $clog2(MAX_QUERY);
  localparam int CA  = $clog2(MAX_COLUMNS);
  localparam int QLW = $clog2(MAX_QUERY + 1);
  localparam int CLW = $clog2(MAX_COLUMNS + 1);
  localparam int AW  = $clog2(MAX_COLUMNS + 2);
  localparam int SW  = ((AW > QLW) ? AW : QLW) + 1;
  localparam int PW  = AW + 5;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_CIG_RD   = 11'b00000000010,
    S_CIG_WR   = 11'b00000000100,
    S_DEL_WR   = 11'b00000001000,
    S_SKIP_RD  = 11'b00000010000,
    S_SKIP_CHK = 11'b00000100000,
    S_POST     = 11'b00001000000,
    S_GAP_RD   = 11'b00010000000,
    S_GAP_CHK  = 11'b00100000000,
    S_SUM      = 11'b01000000000,
    S_FETCH    = 11'b10000000000
  } state_t;

  state_t state;

  logic [7:0] query_store [MAX_QUERY];
  logic [7:0] qrow_store  [MAX_COLUMNS];
  logic [7:0] srow_store  [MAX_COLUMNS];

  logic [QLW-1:0] query_length;
  logic [CLW-1:0] column_count;
  logic [AW-1:0]  number_accum;
  logic           first_op;
  logic           digit_seen;
  logic [QLW-1:0] query_begin;
  logic [QLW-1:0] query_end;
  logic [CLW-1:0] subject_end;
  logic [CLW-1:0] md_ptr;
  logic           md_delete;
  logic [CLW-1:0] fetch_ptr;
  logic [2:0]     err;
  logic [AW-1:0]  remain;
  logic [QLW-1:0] qrd_ptr;
  logic           run_ins;
  logic [7:0]     cur_char;
  logic           cur_last;

  logic [7:0]     qdata;
  logic [7:0]     qrow_data;
  logic [7:0]     sdata;

  logic           row_we;
  logic [CA-1:0]  row_waddr;
  logic [7:0]     qrow_wdata;
  logic           srow_we;
  logic [CA-1:0]  srow_waddr;
  logic [7:0]     srow_wdata;
  logic [CA-1:0]  srow_raddr;

  logic [PW-1:0]  acc_prod;
  logic [AW-1:0]  acc_sat;
  logic [SW-1:0]  num_ext;
  logic [SW-1:0]  qsum;
  logic [SW-1:0]  csum;
  logic [31:0]    qb_wide;
  logic [31:0]    qe_wide;
  logic [31:0]    se_wide;

  assign cmd_take = (state == S_IDLE);

  // Saturating decimal accumulate
  always_comb begin
    acc_prod = PW'(number_accum) * PW'(10) + PW'(cmd.digit);
    acc_sat  = (acc_prod > PW'(MAX_COLUMNS + 1)) ? AW'(MAX_COLUMNS + 1) : AW'(acc_prod);
    num_ext  = SW'(number_accum);
    qsum     = SW'(query_end) + num_ext;
    csum     = SW'(column_count) + num_ext;
    qb_wide  = 32'(query_begin);
    qe_wide  = 32'(query_end);
    se_wide  = 32'(subject_end);
  end

  // Row store write port
  always_comb begin
    row_we     = (state == S_CIG_WR) || (state == S_DEL_WR);
    row_waddr  = column_count[CA-1:0];
    qrow_wdata = (state == S_CIG_WR) ? qdata : cme_pkg::CH_GAP;
    srow_we    = row_we || ((state == S_GAP_CHK) && (sdata != cme_pkg::CH_GAP) &&
                 !(md_delete && (sdata != cme_pkg::CH_N)));
    srow_waddr = (state == S_GAP_CHK) ? md_ptr[CA-1:0] : column_count[CA-1:0];
    if (state == S_GAP_CHK)     srow_wdata = cur_char;
    else if (state == S_DEL_WR) srow_wdata = cme_pkg::CH_N;
    else if (run_ins)           srow_wdata = cme_pkg::CH_GAP;
    else                        srow_wdata = qdata;
    srow_raddr = ((state == S_SKIP_RD) || (state == S_GAP_RD)) ? md_ptr[CA-1:0]
                                                              : fetch_ptr[CA-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && (state == S_IDLE) && (cmd.item.req_type == cme_pkg::REQ_QUERY) &&
        (err == cme_pkg::ERR_NONE) && (query_length < QLW'(MAX_QUERY))) begin
      query_store[query_length[QA-1:0]] <= cmd.item.char_value;
    end
    qdata <= query_store[qrd_ptr[QA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (row_we) qrow_store[row_waddr] <= qrow_wdata;
    qrow_data <= qrow_store[fetch_ptr[CA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (srow_we) srow_store[srow_waddr] <= srow_wdata;
    sdata <= srow_store[srow_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      query_length <= '0;
      column_count <= '0;
      number_accum <= '0;
      first_op     <= 1'b1;
      digit_seen   <= 1'b0;
      query_begin  <= '0;
      query_end    <= '0;
      subject_end  <= '0;
      md_ptr       <= '0;
      md_delete    <= 1'b0;
      fetch_ptr    <= '0;
      err          <= cme_pkg::ERR_NONE;
      result_valid <= 1'b0;
      run_ins      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_char <= cmd.item.char_value;
            cur_last <= cmd.item.is_last;
            case (cmd.item.req_type)
              cme_pkg::REQ_QUERY: begin
                if (err == cme_pkg::ERR_NONE) begin
                  if (query_length >= QLW'(MAX_QUERY)) err <= cme_pkg::ERR_FULL;
                  else query_length <= query_length + QLW'(1);
                end
              end
              cme_pkg::REQ_CIGAR: begin
                if (err == cme_pkg::ERR_NONE) begin
                  if (cmd.is_digit) begin
                    number_accum <= acc_sat;
                    digit_seen   <= 1'b1;
                    if (cmd.item.is_last) err <= cme_pkg::ERR_MALFORMED;
                  end else begin
                    first_op     <= 1'b0;
                    number_accum <= '0;
                    digit_seen   <= 1'b0;
                    if (!digit_seen) begin
                      err <= cme_pkg::ERR_MALFORMED;
                    end else if ((cmd.item.char_value == cme_pkg::CH_M) ||
                                 (cmd.item.char_value == cme_pkg::CH_I)) begin
                      if (qsum > SW'(query_length)) begin
                        err <= cme_pkg::ERR_Q_OVERRUN;
                      end else if (csum > SW'(MAX_COLUMNS)) begin
                        err <= cme_pkg::ERR_FULL;
                      end else begin
                        qrd_ptr   <= query_end;
                        query_end <= QLW'(qsum);
                        if (cmd.item.char_value == cme_pkg::CH_M)
                          subject_end <= subject_end + CLW'(number_accum);
                        run_ins <= (cmd.item.char_value == cme_pkg::CH_I);
                        remain  <= number_accum;
                        if (number_accum != '0) state <= S_CIG_RD;
                      end
                    end else if (cmd.item.char_value == cme_pkg::CH_D) begin
                      if (csum > SW'(MAX_COLUMNS)) begin
                        err <= cme_pkg::ERR_FULL;
                      end else begin
                        subject_end <= subject_end + CLW'(number_accum);
                        remain      <= number_accum;
                        if (number_accum != '0) state <= S_DEL_WR;
                      end
                    end else if (cmd.item.char_value == cme_pkg::CH_S) begin
                      if (first_op) begin
                        if (num_ext > SW'(query_length)) begin
                          err <= cme_pkg::ERR_Q_OVERRUN;
                        end else begin
                          query_begin <= QLW'(number_accum);
                          query_end   <= QLW'(number_accum);
                        end
                      end
                    end else begin
                      err <= cme_pkg::ERR_BAD_OP;
                    end
                  end
                end
              end
              cme_pkg::REQ_MD: begin
                if ((err != cme_pkg::ERR_NONE) || cmd.is_digit) begin
                  if (err == cme_pkg::ERR_NONE) begin
                    md_delete    <= 1'b0;
                    number_accum <= acc_sat;
                  end
                  if (cmd.item.is_last) state <= S_SUM;
                end else begin
                  remain <= number_accum;
                  state  <= (number_accum == '0) ? S_POST : S_SKIP_RD;
                end
              end
              cme_pkg::REQ_FETCH: begin
                if (fetch_ptr < column_count) state <= S_FETCH;
              end
              cme_pkg::REQ_START: begin
                query_length <= '0;
                column_count <= '0;
                number_accum <= '0;
                first_op     <= 1'b1;
                digit_seen   <= 1'b0;
                query_begin  <= '0;
                query_end    <= '0;
                subject_end  <= '0;
                md_ptr       <= '0;
                md_delete    <= 1'b0;
                fetch_ptr    <= '0;
                err          <= cme_pkg::ERR_NONE;
              end
              default: begin
              end
            endcase
          end
        end
        S_CIG_RD: begin
          state <= S_CIG_WR;
        end
        S_CIG_WR: begin
          column_count <= column_count + CLW'(1);
          qrd_ptr      <= qrd_ptr + QLW'(1);
          remain       <= remain - AW'(1);
          state        <= (remain == AW'(1)) ? S_IDLE : S_CIG_RD;
        end
        S_DEL_WR: begin
          column_count <= column_count + CLW'(1);
          remain       <= remain - AW'(1);
          if (remain == AW'(1)) state <= S_IDLE;
        end
        S_SKIP_RD: begin
          if (md_ptr >= column_count) begin
            err   <= cme_pkg::ERR_MD_OVER;
            state <= cur_last ? S_SUM : S_IDLE;
          end else begin
            state <= S_SKIP_CHK;
          end
        end
        S_SKIP_CHK: begin
          md_ptr <= md_ptr + CLW'(1);
          if (sdata != cme_pkg::CH_GAP) begin
            remain <= remain - AW'(1);
            state  <= (remain == AW'(1)) ? S_POST : S_SKIP_RD;
          end else begin
            state <= S_SKIP_RD;
          end
        end
        S_POST: begin
          number_accum <= '0;
          if (cur_char == cme_pkg::CH_CARET) begin
            md_delete <= 1'b1;
            state     <= cur_last ? S_SUM : S_IDLE;
          end else begin
            state <= S_GAP_RD;
          end
        end
        S_GAP_RD: begin
          if (md_ptr >= column_count) begin
            err   <= cme_pkg::ERR_MD_OVER;
            state <= cur_last ? S_SUM : S_IDLE;
          end else begin
            state <= S_GAP_CHK;
          end
        end
        S_GAP_CHK: begin
          if (sdata == cme_pkg::CH_GAP) begin
            md_ptr <= md_ptr + CLW'(1);
            state  <= S_GAP_RD;
          end else begin
            if (md_delete && (sdata != cme_pkg::CH_N)) err <= cme_pkg::ERR_MALFORMED;
            else md_ptr <= md_ptr + CLW'(1);
            state <= cur_last ? S_SUM : S_IDLE;
          end
        end
        S_SUM: begin
          number_accum         <= '0;
          result_valid         <= 1'b1;
          result.result_kind   <= cme_pkg::RES_SUMMARY;
          result.query_col     <= 8'd0;
          result.subject_col   <= 8'd0;
          result.col_last      <= 1'b0;
          result.q_begin       <= qb_wide[12:0];
          result.q_end         <= qe_wide[12:0];
          result.s_begin       <= 1'b0;
          result.s_end         <= se_wide[13:0];
          result.error_code    <= err;
          state                <= S_IDLE;
        end
        S_FETCH: begin
          fetch_ptr            <= fetch_ptr + CLW'(1);
          result_valid         <= 1'b1;
          result.result_kind   <= cme_pkg::RES_COLUMN;
          result.query_col     <= qrow_data;
          result.subject_col   <= sdata;
          result.col_last      <= (fetch_ptr + CLW'(1) == column_count);
          result.q_begin       <= 13'd0;
          result.q_end         <= 13'd0;
          result.s_begin       <= 1'b0;
          result.s_end         <= 14'd0;
          result.error_code    <= cme_pkg::ERR_NONE;
          state                <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cigar_md_alignment_expander.sv
// ----------------------------------------------------------------------------
// cigar_md_alignment_expander
// Rebuilds a pairwise alignment from query bases, a CIGAR and an MD string.
// ----------------------------------------------------------------------------
// Usage: drive item and raise start; a transfer happens on a clock edge with
// start high and busy low. Send the query bases, then CIGAR characters, then
// MD characters; the MD character flagged is_last yields one summary
// transfer on result, marked by result_valid for one cycle. Fetch requests
// then return one alignment column each, col_last on the final one. A start
// record request clears the record state.
// Steps: a base or digit is handled in the executor's idle state; an M or I
// run reads and then writes each column, a D run writes each column directly
// (one store port each); an MD letter or caret reads and checks each subject
// column it visits. A fetch, or a summary on an MD digit, passes through the
// S_FETCH or S_SUM state before its result is registered; a summary on a
// letter follows the letter's walk through the S_SUM state.
// A two-entry queue sits in front, so start can be taken while the executor
// works; busy rises only when the queue is full.
// Reset clears the state machine, the queue and the record registers; stores
// need no clearing. The receiver cannot stall: every result is presented for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cigar_md_alignment_expander #(
  parameter int MAX_QUERY   = 4096,
  parameter int MAX_COLUMNS = 8192
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire cme_pkg::item_t item,
  output logic                busy,
  output logic                result_valid,
  output cme_pkg::result_t    result
);

  // Handoff between the queue and the executor
  logic          cmd_valid;
  logic          cmd_take;
  cme_pkg::cmd_t cmd;

  // Accept and classify, hold up to two items
  cme_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // Execute one command at a time
  cme_back #(
    .MAX_QUERY   (MAX_QUERY),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

FILE: tb/cigar_md_alignment_expander_tb.sv
// ----------------------------------------------------------------------------
// cigar_md_alignment_expander_tb
// Self-checking bench for the CIGAR/MD alignment expander: a directed table
// of record streams, two store-limit records, then random records with
// random content, broken streams and noise. Every accepted request goes
// through a local predictor, and each result transfer is compared field by
// field with the oldest expected result.
// ----------------------------------------------------------------------------
`default_nettype none

module cigar_md_alignment_expander_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH   = 4096;
  localparam int CDEPTH   = 8192;
  localparam int RUN_CAP  = CDEPTH + 1;
  localparam int IDLE_MAX = 40000;
  localparam int N_RANDOM = 1300;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  cme_pkg::item_t   item = '0;
  logic             busy;
  logic             result_valid;
  cme_pkg::result_t result;

  cigar_md_alignment_expander dut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .result_valid(result_valid), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the record being rebuilt
  // --------------------------------------------------------------------------
  logic [7:0]  base_mem [0:QDEPTH-1];
  logic [7:0]  qrow_mem [0:CDEPTH-1];
  logic [7:0]  srow_mem [0:CDEPTH-1];
  int unsigned n_bases, n_cols, run_len, q_first, q_last, s_last;
  int unsigned md_pos, fetch_pos;
  logic [2:0]  sticky_err;
  bit          lead_pending, md_deleting, have_digits;

  typedef struct packed {
    bit               typed;
    cme_pkg::result_t res;
  } typed_exp_t;

  cme_pkg::result_t pending_results[$];
  typed_exp_t       typed_per_transfer[$];
  int               mismatches = 0;
  int               sent_count = 0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= cme_pkg::CH_ZERO && c <= cme_pkg::CH_NINE;
  endfunction

  function automatic int unsigned add_digit(int unsigned acc, logic [7:0] c);
    int unsigned v;
    v = acc * 10 + (c - cme_pkg::CH_ZERO);
    return (v > RUN_CAP) ? RUN_CAP : v;
  endfunction

  function automatic void flag_err(logic [2:0] e);
    if (sticky_err == cme_pkg::ERR_NONE) sticky_err = e;
  endfunction

  function automatic void clear_record();
    n_bases = 0; n_cols = 0; run_len = 0; q_first = 0; q_last = 0; s_last = 0;
    md_pos = 0; fetch_pos = 0; sticky_err = cme_pkg::ERR_NONE;
    lead_pending = 1'b1; md_deleting = 1'b0; have_digits = 1'b0;
  endfunction

  function automatic void expand_cigar(logic [7:0] c, bit last);
    int unsigned n;
    bit lead;
    logic [7:0] b;
    if (is_digit(c)) begin
      run_len = add_digit(run_len, c);
      have_digits = 1'b1;
      if (last) flag_err(cme_pkg::ERR_MALFORMED);
      return;
    end
    lead = lead_pending;
    lead_pending = 1'b0;
    if (!have_digits) begin
      run_len = 0;
      flag_err(cme_pkg::ERR_MALFORMED);
      return;
    end
    n = run_len;
    run_len = 0;
    have_digits = 1'b0;
    if (c == cme_pkg::CH_M || c == cme_pkg::CH_I) begin
      if (q_last + n > n_bases) begin flag_err(cme_pkg::ERR_Q_OVERRUN); return; end
      if (n_cols + n > CDEPTH) begin flag_err(cme_pkg::ERR_FULL); return; end
      for (int unsigned k = 0; k < n; k++) begin
        b = base_mem[(q_last + k) % QDEPTH];
        qrow_mem[n_cols] = b;
        srow_mem[n_cols] = (c == cme_pkg::CH_M) ? b : cme_pkg::CH_GAP;
        n_cols++;
      end
      q_last += n;
      if (c == cme_pkg::CH_M) s_last += n;
    end else if (c == cme_pkg::CH_D) begin
      if (n_cols + n > CDEPTH) begin flag_err(cme_pkg::ERR_FULL); return; end
      for (int unsigned k = 0; k < n; k++) begin
        qrow_mem[n_cols] = cme_pkg::CH_GAP;
        srow_mem[n_cols] = cme_pkg::CH_N;
        n_cols++;
      end
      s_last += n;
    end else if (c == cme_pkg::CH_S) begin
      if (lead) begin
        if (n > n_bases) begin flag_err(cme_pkg::ERR_Q_OVERRUN); return; end
        q_first = n;
        q_last = n;
      end
    end else begin
      flag_err(cme_pkg::ERR_BAD_OP);
    end
  endfunction

  function automatic void patch_subject(logic [7:0] c);
    int unsigned walked;
    walked = 0;
    if (is_digit(c)) begin
      md_deleting = 1'b0;
      run_len = add_digit(run_len, c);
      return;
    end
    // skip the pending count of non-gap subject columns
    while (walked < run_len) begin
      if (md_pos >= n_cols) begin flag_err(cme_pkg::ERR_MD_OVER); return; end
      if (srow_mem[md_pos] != cme_pkg::CH_GAP) walked++;
      md_pos++;
    end
    run_len = 0;
    if (c == cme_pkg::CH_CARET) begin
      md_deleting = 1'b1;
      return;
    end
    while (md_pos < n_cols && srow_mem[md_pos] == cme_pkg::CH_GAP) md_pos++;
    if (md_pos >= n_cols) begin flag_err(cme_pkg::ERR_MD_OVER); return; end
    if (md_deleting && srow_mem[md_pos] != cme_pkg::CH_N) begin
      flag_err(cme_pkg::ERR_MALFORMED);
      return;
    end
    srow_mem[md_pos] = c;
    md_pos++;
  endfunction

  // Advance the record by one request; report the result it causes, if any
  function automatic bit predict_request(cme_pkg::item_t it, output cme_pkg::result_t r);
    r = '0;
    case (it.req_type)
      cme_pkg::REQ_QUERY: begin
        if (sticky_err != cme_pkg::ERR_NONE) return 1'b0;
        if (n_bases >= QDEPTH) begin flag_err(cme_pkg::ERR_FULL); return 1'b0; end
        base_mem[n_bases] = it.char_value;
        n_bases++;
        return 1'b0;
      end
      cme_pkg::REQ_CIGAR: begin
        if (sticky_err == cme_pkg::ERR_NONE) expand_cigar(it.char_value, it.is_last);
        return 1'b0;
      end
      cme_pkg::REQ_MD: begin
        if (sticky_err == cme_pkg::ERR_NONE) patch_subject(it.char_value);
        if (!it.is_last) return 1'b0;
        run_len = 0;
        r.result_kind = cme_pkg::RES_SUMMARY;
        r.q_begin     = q_first[12:0];
        r.q_end       = q_last[12:0];
        r.s_end       = s_last[13:0];
        r.error_code  = sticky_err;
        return 1'b1;
      end
      cme_pkg::REQ_FETCH: begin
        if (fetch_pos >= n_cols) return 1'b0;
        r.result_kind = cme_pkg::RES_COLUMN;
        r.query_col   = qrow_mem[fetch_pos];
        r.subject_col = srow_mem[fetch_pos];
        r.col_last    = (fetch_pos + 1 == n_cols);
        fetch_pos++;
        return 1'b1;
      end
      cme_pkg::REQ_START: begin
        clear_record();
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on every input transfer, check every result transfer.
  // Both sample the values present just before the edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    typed_exp_t       te;
    cme_pkg::result_t r, want;
    if (!rst) begin
      if (start && !busy) begin
        te = typed_per_transfer.pop_front();
        if (predict_request(item, r))
          pending_results.insert(pending_results.size(), te.typed ? te.res : r);
      end
      if (result_valid) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", result);
        end else begin
          want = pending_results.pop_front();
          if (result.result_kind !== want.result_kind || result.query_col !== want.query_col ||
              result.subject_col !== want.subject_col || result.col_last !== want.col_last ||
              result.q_begin !== want.q_begin || result.q_end !== want.q_end ||
              result.s_begin !== want.s_begin || result.s_end !== want.s_end ||
              result.error_code !== want.error_code) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", want, result);
          end
        end
      end
    end
  end

  // Watchdog: count cycles in which no transfer of either kind happens
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("cigar_md_alignment_expander test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender: bursts of back-to-back transfers with random gaps between them
  // --------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send(logic [2:0] rq, logic [7:0] ch, bit lst,
                      bit typed = 1'b0, cme_pkg::result_t res = '0);
    typed_exp_t te;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    te.typed = typed;
    te.res   = res;
    typed_per_transfer.insert(typed_per_transfer.size(), te);
    start <= 1'b1;
    item  <= '{req_type: rq, char_value: ch, is_last: lst};
    if (rq <= cme_pkg::REQ_START) sent_count++;
    do @(posedge clk); while (busy);
  endtask

  function automatic cme_pkg::result_t summary(int qb, int qe, int se, logic [2:0] e);
    cme_pkg::result_t r;
    r = '0;
    r.result_kind = cme_pkg::RES_SUMMARY;
    r.q_begin = 13'(qb); r.q_end = 13'(qe); r.s_end = 14'(se); r.error_code = e;
    return r;
  endfunction

  typedef struct {
    logic [2:0]       rq;
    logic [7:0]       ch;
    bit               lst;
    bit               typed;
    cme_pkg::result_t res;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic void add_row(logic [2:0] rq, logic [7:0] ch, bit lst,
                                  bit typed = 1'b0, cme_pkg::result_t res = '0);
    directed_rows.insert(directed_rows.size(), '{rq, ch, lst, typed, res});
  endfunction

  function automatic void append_char(ref logic [7:0] q[$], input logic [7:0] c);
    q.insert(q.size(), c);
  endfunction

  function automatic void push_number(ref logic [7:0] q[$], input int n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) append_char(q, s[i]);
  endfunction

  task automatic send_stream(logic [2:0] rq, ref logic [7:0] q[$]);
    foreach (q[i]) send(rq, q[i], i == q.size() - 1);
  endtask

  // One random record: bases, CIGAR, MD, fetches; sometimes broken or noisy
  task automatic random_record();
    logic [7:0] cig[$], md[$], acgt[4];
    int qlen, avail, nops, n, cols, pend, mode;
    logic [7:0] op;
    acgt = '{8'h41, 8'h43, 8'h47, 8'h54};
    qlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(1, 24);
    send(cme_pkg::REQ_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    for (int i = 0; i < qlen; i++)
      send(cme_pkg::REQ_QUERY, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : acgt[$urandom_range(0, 3)],
           1'($urandom_range(0, 1)));
    avail = qlen;
    cols = 0;
    pend = 0;
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(0, avail / 2);
      push_number(cig, n);
      append_char(cig, cme_pkg::CH_S);
      avail -= n;
    end
    nops = $urandom_range(1, 5);
    for (int k = 0; k < nops; k++) begin
      case ($urandom_range(0, 3))
        0, 1: op = cme_pkg::CH_M;
        2:    op = cme_pkg::CH_I;
        default: op = cme_pkg::CH_D;
      endcase
      if (avail == 0) op = cme_pkg::CH_D;
      n = (op == cme_pkg::CH_D) ? $urandom_range(1, 4)
                                : $urandom_range(1, (avail > 8) ? 8 : avail);
      if (op != cme_pkg::CH_D) avail -= n;
      cols += n;
      push_number(cig, n);
      append_char(cig, op);
      if (op == cme_pkg::CH_M) begin
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(0, 3) == 0) begin
            push_number(md, pend);
            append_char(md, acgt[$urandom_range(0, 3)]);
            pend = 0;
          end else pend++;
        end
      end else if (op == cme_pkg::CH_D) begin
        push_number(md, pend);
        pend = 0;
        append_char(md, cme_pkg::CH_CARET);
        repeat (n) append_char(md, acgt[$urandom_range(0, 3)]);
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      push_number(cig, $urandom_range(0, 3));
      append_char(cig, cme_pkg::CH_S);
    end
    push_number(md, pend);
    // broken streams
    if ($urandom_range(0, 6) == 0) begin
      mode = $urandom_range(0, 3);
      case (mode)
        0: cig[$urandom_range(0, cig.size() - 1)] = 8'($urandom_range(0, 255));
        1: cig.delete($urandom_range(0, cig.size() - 1));
        2: append_char(cig, 8'(cme_pkg::CH_ZERO + $urandom_range(0, 9)));
        default: begin
          push_number(cig, $urandom_range(1, 99));
          append_char(cig, cme_pkg::CH_M);
        end
      endcase
    end
    if ($urandom_range(0, 6) == 0) begin
      if ($urandom_range(0, 1))
        md[$urandom_range(0, md.size() - 1)] = 8'($urandom_range(0, 255));
      else begin
        push_number(md, $urandom_range(0, 20));
        append_char(md, acgt[0]);
      end
    end
    if (cig.size() > 0) send_stream(cme_pkg::REQ_CIGAR, cig);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        send(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
    send_stream(cme_pkg::REQ_MD, md);
    repeat (cols + $urandom_range(0, 2))
      send(cme_pkg::REQ_FETCH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [7:0] big[$];
    clear_record();

    // after reset: nothing to fetch, a trailing MD number is ignored
    add_row(cme_pkg::REQ_FETCH, 8'h00, 1'b0);
    add_row(cme_pkg::REQ_MD,    8'h37, 1'b1, 1'b1, summary(0, 0, 0, cme_pkg::ERR_NONE));
    // record 1S1M1I2D over bases 00 FF 41, MD 1^AC
    add_row(cme_pkg::REQ_START, 8'hFF, 1'b1);
    add_row(cme_pkg::REQ_QUERY, 8'h00, 1'b0);
    add_row(cme_pkg::REQ_QUERY, 8'hFF, 1'b1);
    add_row(cme_pkg::REQ_QUERY, 8'h41, 1'b0);
    add_row(cme_pkg::REQ_CIGAR, 8'h31, 1'b0);
    add_row(cme_pkg::REQ_CIGAR, cme_pkg::CH_S, 1'b0);
    add_row(cme_pkg::REQ_CIGAR, 8'h31, 1'b0);
    add_row(cme_pkg::REQ_CIGAR, cme_pkg::CH_M, 1'b0);
    add_row(cme_pkg::REQ_CIGAR, 8'h31, 1'b0);
    add_row(cme_pkg::REQ_CIGAR, cme_pkg::CH_I, 1'b0);
    add_row(cme_pkg::REQ_CIGAR, 8'h32, 1'b0);
    add_row(cme_pkg::REQ_CIGAR, cme_pkg::CH_D, 1'b1);
    add_row(cme_pkg::REQ_MD,    8'h31, 1'b0);
    add_row(cme_pkg::REQ_MD,    cme_pkg::CH_CARET, 1'b0);
    add_row(cme_pkg::REQ_MD,    8'h41, 1'b0);
    add_row(cme_pkg::REQ_MD,    8'h43, 1'b1, 1'b1, summary(1, 3, 3, cme_pkg::ERR_NONE));
    repeat (5) add_row(cme_pkg::REQ_FETCH, 8'h00, 1'b0);
    // unknown op, then an op with no run length
    add_row(cme_pkg::REQ_START, 8'h00, 1'b0);
    add_row(cme_pkg::REQ_CIGAR, 8'h31, 1'b0);
    add_row(cme_pkg::REQ_CIGAR, 8'h58, 1'b0);
    add_row(cme_pkg::REQ_MD,    8'h30, 1'b1, 1'b1, summary(0, 0, 0, cme_pkg::ERR_BAD_OP));
    add_row(cme_pkg::REQ_START, 8'h00, 1'b0);
    add_row(cme_pkg::REQ_CIGAR, cme_pkg::CH_M, 1'b1);
    add_row(cme_pkg::REQ_MD,    8'h30, 1'b1, 1'b1,
            summary(0, 0, 0, cme_pkg::ERR_MALFORMED));
    add_row(3'd7,               8'hFF, 1'b1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send(directed_rows[i].rq, directed_rows[i].ch, directed_rows[i].lst,
           directed_rows[i].typed, directed_rows[i].res);

    // full query store, one maximal M run, then a base that overflows the store
    send(cme_pkg::REQ_START, 8'h00, 1'b0);
    repeat (QDEPTH) send(cme_pkg::REQ_QUERY, 8'($urandom_range(0, 255)), 1'b0);
    push_number(big, QDEPTH);
    append_char(big, cme_pkg::CH_M);
    send_stream(cme_pkg::REQ_CIGAR, big);
    send(cme_pkg::REQ_MD, 8'h30, 1'b1);
    repeat (3) send(cme_pkg::REQ_FETCH, 8'h00, 1'b0);
    send(cme_pkg::REQ_QUERY, 8'h41, 1'b0);
    send(cme_pkg::REQ_MD, 8'h30, 1'b1, 1'b1,
         summary(0, QDEPTH % 8192, QDEPTH % 16384, cme_pkg::ERR_FULL));
    // a deletion that would overflow the column store
    big.delete();
    push_number(big, 99999);
    append_char(big, cme_pkg::CH_D);
    send(cme_pkg::REQ_START, 8'h00, 1'b0);
    send_stream(cme_pkg::REQ_CIGAR, big);
    send(cme_pkg::REQ_MD, 8'h30, 1'b1, 1'b1, summary(0, 0, 0, cme_pkg::ERR_FULL));

    sent_count = 0;
    while (sent_count < N_RANDOM) random_record();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0)
      $display("cigar_md_alignment_expander test passed");
    else
      $display("cigar_md_alignment_expander test failed");
    $finish;
  end

endmodule

`default_nettype wire
